[rtl/wide_signed_integer_alu_macros.svh]
// Assertion macros for the wide signed integer ALU.
`ifndef WIDE_SIGNED_INTEGER_ALU_MACROS_SVH
`define WIDE_SIGNED_INTEGER_ALU_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WSA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSA_ASSERT(label, clk, rst_n, prop, msg)
`define WSA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/wsalu_pkg.sv]
// ----------------------------------------------------------------------------
// wsalu_pkg
// Types and constants shared by the wide signed integer ALU modules.
// ----------------------------------------------------------------------------
`default_nettype none
package wsalu_pkg;
  localparam int WORD_BITS  = 512;
  localparam int LIMB_BITS  = 64;
  localparam int NLIMBS     = WORD_BITS / LIMB_BITS;
  localparam int LIDX_W     = $clog2(NLIMBS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);

  typedef logic [2:0] op_t;
  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_REM = 3'd4;
  localparam op_t OP_CMP = 3'd5;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_DIV, ST_FIX, ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // write limb into operands
    logic simple;    // run add/sub/cmp into result
    logic prep;      // set up mul or div
    logic mul_step;
    logic div_step;
    logic fix;       // sign fix of quotient/remainder
    logic shift_out; // advance output limb
  } dp_cmd_t;

  typedef struct packed {
    logic dbz;
  } dp_stat_t;
endpackage
`default_nettype wire

[rtl/wide_signed_integer_alu.sv]
// ----------------------------------------------------------------------------
// wide_signed_integer_alu
// 512-bit two's-complement ALU: add, sub, mul, div, rem, signed compare.
// ----------------------------------------------------------------------------
// Operands enter one 64-bit limb pair per transaction, low limb first; the
// transaction with in_last_limb starts the operation. Eight result limbs then
// leave on consecutive cycles with out_valid high; the receiver cannot stall
// them. Add, sub, compare and unused codes are computed once the last limb is
// registered; multiply and divide/remainder first step one bit per cycle
// through the shift-add or restoring subtract unit, and a zero divisor skips
// the divide steps. Busy falls in the cycle that carries the last result, so
// the next transaction can be taken at the edge that ends it.
`default_nettype none
module wide_signed_integer_alu (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [2:0]                      in_req_type,
  input  wire logic [wsalu_pkg::LIMB_BITS-1:0] in_limb_a,
  input  wire logic [wsalu_pkg::LIMB_BITS-1:0] in_limb_b,
  input  wire logic                            in_last_limb,
  output logic                                 out_valid,
  output logic [wsalu_pkg::LIMB_BITS-1:0]      out_result_limb,
  output logic                                 out_result_last,
  output logic [1:0]                           out_compare_code,
  output logic                                 out_divide_by_zero
);
  import wsalu_pkg::*;

  dp_cmd_t  ccmd, dcmd;
  dp_stat_t stat;
  op_t      op;
  logic     ovalid, olast, simple_r;

  wsalu_ctrl u_ctrl (
    .clk, .rst_n, .start, .last_limb(in_last_limb), .req(in_req_type), .stat,
    .busy, .op, .cmd(ccmd), .out_valid(ovalid), .out_last(olast)
  );

  // Simple operations are computed once the final limb is registered.
  always_ff @(posedge clk) begin
    if (!rst_n) simple_r <= 1'b0;
    else simple_r <= ccmd.load && in_last_limb && !(in_req_type == OP_MUL ||
                     in_req_type == OP_DIV || in_req_type == OP_REM);
  end

  // Hold the result stream back through sv_r and sl_r so simple results are ready.
  logic sv_r, sl_r;
  always_comb begin
    dcmd = ccmd;
    dcmd.simple = simple_r;
    dcmd.shift_out = sv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0; sl_r <= 1'b0;
    end else begin
      sv_r <= ovalid; sl_r <= olast;
    end
  end

  wsalu_datapath u_dp (
    .clk, .rst_n, .cmd(dcmd), .op, .limb_a(in_limb_a), .limb_b(in_limb_b),
    .stat, .res_limb(out_result_limb), .cmp_code(out_compare_code),
    .dbz(out_divide_by_zero)
  );

  assign out_valid       = sv_r;
  assign out_result_last = sl_r;
endmodule
`default_nettype wire

[rtl/wsalu_datapath.sv]
// ----------------------------------------------------------------------------
// wsalu_datapath
// Operand registers, shift-add multiplier, restoring divider, output limbs.
// ----------------------------------------------------------------------------
`default_nettype none
module wsalu_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire wsalu_pkg::dp_cmd_t           cmd,
  input  wire wsalu_pkg::op_t               op,
  input  wire logic [wsalu_pkg::LIMB_BITS-1:0] limb_a,
  input  wire logic [wsalu_pkg::LIMB_BITS-1:0] limb_b,
  output wsalu_pkg::dp_stat_t               stat,
  output logic [wsalu_pkg::LIMB_BITS-1:0]   res_limb,
  output logic [1:0]                        cmp_code,
  output logic                              dbz
);
  import wsalu_pkg::*;

  logic [WORD_BITS-1:0] a_r, b_r, acc_r, acc_nxt, q_r, q_nxt, rem_r, rem_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt, n_r, n_nxt;
  logic [LIDX_W-1:0]    idx_r;
  logic                 sa_r, sb_r, sa_nxt, sb_nxt;
  logic [1:0]           cmp_r, cmp_nxt;
  logic                 dbz_r, dbz_nxt;
  logic [WORD_BITS-1:0] rsh;
  logic [WORD_BITS:0]   rdiff;
  logic                 b_zero;

  assign b_zero = (b_r == '0);
  assign rsh    = {rem_r[WORD_BITS-2:0], n_r[WORD_BITS-1]};
  assign rdiff  = {1'b0, rsh} - {1'b0, b_r};

  always_comb begin
    acc_nxt = acc_r; q_nxt = q_r; rem_nxt = rem_r; res_nxt = res_r; n_nxt = n_r;
    sa_nxt = sa_r; sb_nxt = sb_r; cmp_nxt = cmp_r; dbz_nxt = dbz_r;
    if (cmd.simple) begin
      cmp_nxt = CMP_EQ; dbz_nxt = 1'b0; res_nxt = '0;
      case (op)
        OP_ADD: res_nxt = a_r + b_r;
        OP_SUB: res_nxt = a_r - b_r;
        OP_CMP: begin
          if (a_r == b_r) cmp_nxt = CMP_EQ;
          else if ($signed(a_r) < $signed(b_r)) cmp_nxt = CMP_LT;
          else cmp_nxt = CMP_GT;
        end
        default: res_nxt = '0;
      endcase
    end
    if (cmd.prep) begin
      cmp_nxt = CMP_EQ; dbz_nxt = 1'b0; res_nxt = '0;
      acc_nxt = '0; q_nxt = '0; rem_nxt = '0;
      sa_nxt = a_r[WORD_BITS-1]; sb_nxt = b_r[WORD_BITS-1];
      if (op == OP_MUL) begin
        n_nxt = b_r;
      end else begin
        dbz_nxt = b_zero;
        n_nxt = a_r[WORD_BITS-1] ? (~a_r + 1'b1) : a_r;
      end
    end
    if (cmd.mul_step) begin
      // One bit of b per cycle, most significant first.
      acc_nxt = {acc_r[WORD_BITS-2:0], 1'b0} + (n_r[WORD_BITS-1] ? a_r : '0);
      n_nxt   = {n_r[WORD_BITS-2:0], 1'b0};
      res_nxt = acc_nxt;
    end
    if (cmd.div_step) begin
      // b_r already holds the divisor magnitude here.
      n_nxt = {n_r[WORD_BITS-2:0], 1'b0};
      if (!rdiff[WORD_BITS]) begin
        rem_nxt = rdiff[WORD_BITS-1:0];
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rsh;
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b0};
      end
    end
    if (cmd.fix) begin
      if (dbz_r) res_nxt = '0;
      else if (op == OP_DIV) res_nxt = (sa_r != sb_r) ? (~q_r + 1'b1) : q_r;
      else res_nxt = sa_r ? (~rem_r + 1'b1) : rem_r;
    end
    if (cmd.shift_out) res_nxt = {{LIMB_BITS{1'b0}}, res_r[WORD_BITS-1:LIMB_BITS]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; b_r <= '0; idx_r <= '0; cmp_r <= CMP_EQ; dbz_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        a_r[idx_r*LIMB_BITS +: LIMB_BITS] <= limb_a;
        b_r[idx_r*LIMB_BITS +: LIMB_BITS] <= limb_b;
        idx_r <= idx_r + 1'b1;
      end else if (cmd.prep && op != OP_MUL && b_r[WORD_BITS-1]) begin
        b_r <= ~b_r + 1'b1;
      end else if (cmd.fix && sb_r) begin
        b_r <= ~b_r + 1'b1;
      end
      if (cmd.simple || cmd.prep) idx_r <= '0;
      cmp_r <= cmp_nxt; dbz_r <= dbz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; q_r <= q_nxt; rem_r <= rem_nxt; res_r <= res_nxt;
    n_r <= n_nxt; sa_r <= sa_nxt; sb_r <= sb_nxt;
  end

  assign res_limb  = res_r[LIMB_BITS-1:0];
  assign cmp_code  = cmp_r;
  assign dbz       = dbz_r;
  // The controller decides on the divisor while the operands are settled.
  assign stat.dbz  = b_zero;
endmodule
`default_nettype wire

[rtl/wsalu_ctrl.sv]
// ----------------------------------------------------------------------------
// wsalu_ctrl
// Sequencer: limb collection, iteration count and result streaming.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wide_signed_integer_alu_macros.svh"
module wsalu_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 last_limb,
  input  wire wsalu_pkg::op_t       req,
  input  wire wsalu_pkg::dp_stat_t  stat,
  output logic                      busy,
  output wsalu_pkg::op_t            op,
  output wsalu_pkg::dp_cmd_t        cmd,
  output logic                      out_valid,
  output logic                      out_last
);
  import wsalu_pkg::*;

  state_t state_r, state_nxt;
  logic [BIT_IDX_W-1:0] cnt_r, cnt_nxt;
  op_t op_r, op_nxt;
  logic accept;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; op_nxt = op_r;
    case (state_r)
      ST_IDLE: if (accept && last_limb) begin
        op_nxt = req; cnt_nxt = '0;
        if (req == OP_MUL || req == OP_DIV || req == OP_REM) state_nxt = ST_PREP;
        else state_nxt = ST_OUT;
      end
      ST_PREP: begin
        cnt_nxt = '0;
        if (op_r == OP_MUL) state_nxt = ST_MUL;
        else if (stat.dbz) state_nxt = ST_FIX;
        else state_nxt = ST_DIV;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BIT_IDX_W'(WORD_BITS-1)) begin
          state_nxt = ST_OUT; cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BIT_IDX_W'(WORD_BITS-1)) begin
          state_nxt = ST_FIX; cnt_nxt = '0;
        end
      end
      ST_FIX: begin
        state_nxt = ST_OUT; cnt_nxt = '0;
      end
      ST_OUT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BIT_IDX_W'(NLIMBS-1)) begin
          state_nxt = ST_IDLE; cnt_nxt = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0; busy = 1'b1; out_valid = 1'b0; out_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = accept;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_MUL:  cmd.mul_step = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIX:  cmd.fix = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        out_last  = (cnt_r == BIT_IDX_W'(NLIMBS-1));
        cmd.shift_out = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // The simple ops are evaluated in the cycle after the last limb lands.
  always_comb begin
    op = op_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; op_r <= OP_ADD;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; op_r <= op_nxt;
    end
  end

  `WSA_ASSERT(a_busy_out, clk, rst_n, out_valid |-> busy, "result strobe while idle")
  `WSA_ASSERT(a_last_once, clk, rst_n, out_last |=> !out_valid, "result after last limb")
  `WSA_ASSERT(a_no_accept, clk, rst_n, cmd.load |-> state_r == ST_IDLE, "load outside idle")
  `WSA_ASSERT(a_fix_out, clk, rst_n, cmd.fix |=> out_valid, "fix not followed by output")
endmodule
`default_nettype wire
